FILE: hw/rtl/grts_pkg.sv
package grts_pkg;

  // Field widths
  localparam int unsigned PadW   = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned PosW   = 4;
  localparam int unsigned PhaseW = 3;

  // Button patterns, active low
  localparam logic [PadW-1:0] AllReleased  = 12'h0FFF;
  localparam logic [PadW-1:0] ComboRSelect = 12'h07FB;
  localparam logic [PadW-1:0] ComboLSelect = 12'h0BFB;
  localparam logic [PadW-1:0] LrBits       = 12'h0C00;
  localparam logic [ByteW-1:0] ByteReleased = 8'hFF;

  localparam logic [CountW-1:0] CountMax = 8'hFF;
  localparam logic [PosW-1:0]   PosDone  = 4'd8;

  // Register reset values
  localparam logic [CountW-1:0] TriggerReset = 8'd200;
  localparam logic [CountW-1:0] CaptureReset = 8'd30;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] RegTriggerHold = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCaptureHold = 8'd1;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_STROBE = 2'd1,
    CMD_CLOCK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NORMAL       = 2'd0,
    MODE_WAIT_RELEASE = 2'd1,
    MODE_HOLD         = 2'd2
  } mode_t;

  // Expand macro templates, then fold the pad onto the console byte
  function automatic logic [ByteW-1:0] map_buttons(
    input logic [PadW-1:0] pad,
    input logic [PadW-1:0] right_tpl,
    input logic [PadW-1:0] left_tpl,
    input logic            turbo_on
  );
    logic [PadW-1:0]  b;
    logic [ByteW-1:0] v;
    b = pad;
    if (!b[11]) b = b & right_tpl;
    if (!b[10]) b = b & left_tpl;
    v = {b[7:2], b[0], b[8]};
    // turbo A from X, turbo B from Y
    if (!b[9] && turbo_on) v[0] = 1'b0;
    if (!b[1] && turbo_on) v[1] = 1'b0;
    // release Right and Down when opposites are both pressed
    if (!b[7] && !b[6]) v[7] = 1'b1;
    if (!b[5] && !b[4]) v[5] = 1'b1;
    return v;
  endfunction

endpackage

FILE: hw/rtl/gamepad_remap_turbo_shifter_core.sv
// Pad-to-console remapper with turbo, macro templates and a serial shifter.
//
// Input stream (s_*): one word per event. s_tuser carries the command
// (pad poll, console strobe, console clock), s_tdata the 12 active-low pad
// buttons. Output stream (m_*): exactly one word per input word, in order,
// carrying the serial data bit, the mapped console byte, the LED flag and
// the capture flag.
// Configuration (cfg_*): register 0 is the trigger hold count, register 1
// the capture hold count; writes are always taken and unknown indexes are
// dropped. Write only while no words are in flight.
//
// From input accept to output valid there is one input register, then the
// poll/shift logic feeding the output register, where all state is updated.
// Throughput is one word per cycle while the receiver takes each output word.
// Reset (rst, synchronous) empties both registers, restores the default
// hold counts, clears the templates and leaves the shifter finished.
// When the receiver stalls the output word holds, the input register
// still fills once, and s_tready falls until the output is taken.
module gamepad_remap_turbo_shifter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] pad_buttons, [15:12] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [0] data_bit, [8:1] console_byte,
                                 // [9] led_on, [10] capturing, [15:11] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Configuration registers
  logic [grts_pkg::CountW-1:0] trigger_hold;
  logic [grts_pkg::CountW-1:0] capture_hold;

  // Input register
  logic                      s1_valid;
  grts_pkg::cmd_t            s1_cmd;
  logic [grts_pkg::PadW-1:0] s1_pad;
  logic                      advance;

  // Block state
  logic [grts_pkg::ByteW-1:0]  mapped_byte, mapped_byte_next;
  logic [grts_pkg::PosW-1:0]   shift_pos, shift_pos_next;
  logic [grts_pkg::PhaseW-1:0] turbo_phase, turbo_phase_next;
  logic [grts_pkg::CountW-1:0] combo_count, combo_count_next;
  logic [grts_pkg::CountW-1:0] capture_count, capture_count_next;
  grts_pkg::mode_t             mode, mode_next;
  logic                        for_right, for_right_next;
  logic [grts_pkg::PadW-1:0]   right_tpl, right_tpl_next;
  logic [grts_pkg::PadW-1:0]   left_tpl, left_tpl_next;

  // Poll working values
  logic                        led, do_map, fire, is_combo;
  logic [grts_pkg::PadW-1:0]   map_pad;
  logic [grts_pkg::CountW-1:0] count_tmp;
  logic                        data_bit;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || advance;

  // Take configuration writes, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_hold <= grts_pkg::TriggerReset;
      capture_hold <= grts_pkg::CaptureReset;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == grts_pkg::RegTriggerHold) trigger_hold <= cfg_data;
      if (cfg_index == grts_pkg::RegCaptureHold) capture_hold <= cfg_data;
    end
  end

  // Load the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_cmd <= grts_pkg::cmd_t'(s_tuser);
      s1_pad <= s_tdata[grts_pkg::PadW-1:0];
    end
  end

  // Poll, strobe and clock handling
  always_comb begin
    mapped_byte_next   = mapped_byte;
    shift_pos_next     = shift_pos;
    turbo_phase_next   = turbo_phase;
    combo_count_next   = combo_count;
    capture_count_next = capture_count;
    mode_next          = mode;
    for_right_next     = for_right;
    right_tpl_next     = right_tpl;
    left_tpl_next      = left_tpl;
    led                = 1'b0;
    do_map             = 1'b0;
    fire               = 1'b0;
    map_pad            = s1_pad;
    is_combo           = (s1_pad == grts_pkg::ComboRSelect) ||
                         (s1_pad == grts_pkg::ComboLSelect);
    count_tmp          = '0;

    unique case (s1_cmd)
      grts_pkg::CMD_POLL: begin
        unique case (mode)
          grts_pkg::MODE_NORMAL: begin
            led    = (s1_pad != grts_pkg::AllReleased);
            do_map = 1'b1;
            if (is_combo) begin
              fire = (combo_count == trigger_hold) && (combo_count != grts_pkg::CountMax);
              if (combo_count != grts_pkg::CountMax) begin
                combo_count_next = combo_count + 1'b1;
              end
              if (fire) begin
                do_map             = 1'b0;
                mapped_byte_next   = grts_pkg::ByteReleased;
                for_right_next     = (s1_pad == grts_pkg::ComboRSelect);
                mode_next          = grts_pkg::MODE_WAIT_RELEASE;
                capture_count_next = '0;
              end
            end else begin
              combo_count_next = '0;
            end
          end
          grts_pkg::MODE_WAIT_RELEASE: begin
            if (s1_pad == grts_pkg::AllReleased) begin
              mode_next          = grts_pkg::MODE_HOLD;
              capture_count_next = '0;
            end
          end
          grts_pkg::MODE_HOLD: begin
            // count consecutive pressed polls, saturating
            if (s1_pad != grts_pkg::AllReleased) begin
              count_tmp = (capture_count != grts_pkg::CountMax) ?
                          capture_count + 1'b1 : capture_count;
            end
            capture_count_next = count_tmp;
            if (count_tmp >= capture_hold) begin
              if (for_right) right_tpl_next = s1_pad | grts_pkg::LrBits;
              else           left_tpl_next  = s1_pad | grts_pkg::LrBits;
              mode_next          = grts_pkg::MODE_NORMAL;
              capture_count_next = '0;
              map_pad            = grts_pkg::AllReleased;
              do_map             = 1'b1;
            end
          end
          default: begin
            do_map = 1'b0;
          end
        endcase
        if (do_map) begin
          mapped_byte_next = grts_pkg::map_buttons(map_pad, right_tpl, left_tpl,
                                                   !turbo_phase[grts_pkg::PhaseW-1]);
          turbo_phase_next = turbo_phase + 1'b1;
        end
      end
      grts_pkg::CMD_STROBE: begin
        shift_pos_next = '0;
      end
      grts_pkg::CMD_CLOCK: begin
        if (shift_pos < grts_pkg::PosDone) shift_pos_next = shift_pos + 1'b1;
      end
      default: begin
        shift_pos_next = shift_pos;
      end
    endcase

    data_bit = shift_pos_next[grts_pkg::PosW-1] ? 1'b0 :
               mapped_byte_next[shift_pos_next[grts_pkg::PosW-2:0]];
  end

  // Commit state and hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      mapped_byte   <= grts_pkg::ByteReleased;
      shift_pos     <= grts_pkg::PosDone;
      turbo_phase   <= '0;
      combo_count   <= '0;
      capture_count <= '0;
      mode          <= grts_pkg::MODE_NORMAL;
      for_right     <= 1'b0;
      right_tpl     <= grts_pkg::AllReleased;
      left_tpl      <= grts_pkg::AllReleased;
    end else if (advance) begin
      m_tvalid <= s1_valid;
      if (s1_valid) begin
        mapped_byte   <= mapped_byte_next;
        shift_pos     <= shift_pos_next;
        turbo_phase   <= turbo_phase_next;
        combo_count   <= combo_count_next;
        capture_count <= capture_count_next;
        mode          <= mode_next;
        for_right     <= for_right_next;
        right_tpl     <= right_tpl_next;
        left_tpl      <= left_tpl_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_tdata <= {5'b0, (mode_next != grts_pkg::MODE_NORMAL), led,
                  mapped_byte_next, data_bit};
    end
  end

endmodule

FILE: hw/rtl/grts_checker.sv
module grts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_index,
  input logic [7:0]  cfg_data
);

  // Hold a stalled output word
  a_out_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  // No word appears straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  // While capturing the console sees every button released
  a_capture_released: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> m_tdata[8:1] == 8'hFF)
    else $error("console byte not released during capture");

endmodule

bind gamepad_remap_turbo_shifter_core grts_checker u_grts_checker (.*);

FILE: test/gamepad_remap_turbo_shifter_checker.sv
`timescale 1ns / 100ps
module gamepad_remap_turbo_shifter_checker
  import grts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] pad_buttons, [15:12] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] data_bit, [8:1] console_byte,
                                 // [9] led_on, [10] capturing, [15:11] zero
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          in_flight
);

  // last turbo phase in which X and Y count as pressed
  localparam logic [PhaseW-1:0] TurboOnLast = 3'd3;

  typedef struct packed {
    logic             data_bit;
    logic [ByteW-1:0] console_byte;
    logic             led_on;
    logic             capturing;
  } console_word_t;

  console_word_t console_words_q[$];

  // shadow of the block state
  logic [CountW-1:0] trigger_polls;
  logic [CountW-1:0] hold_polls;
  logic [ByteW-1:0]  console_byte;
  logic [PosW-1:0]   shift_pos;
  logic [PhaseW-1:0] turbo_phase;
  logic [CountW-1:0] combo_polls;
  logic [CountW-1:0] held_polls;
  mode_t             capture_mode;
  logic              for_right;
  logic [PadW-1:0]   right_macro;
  logic [PadW-1:0]   left_macro;

  // expand macros while R or L is down, then lay the pad onto the console byte
  function automatic logic [ByteW-1:0] fold_pad(input logic [PadW-1:0] pad,
                                                input logic turbo_on);
    logic [PadW-1:0]  b;
    logic [ByteW-1:0] v;
    b = pad;
    if (b[11] == 1'b0) b = b & right_macro;
    if (b[10] == 1'b0) b = b & left_macro;
    v[7:2] = b[7:2];
    v[1]   = b[0];
    v[0]   = b[8];
    if (turbo_on && b[9] == 1'b0) v[0] = 1'b0;
    if (turbo_on && b[1] == 1'b0) v[1] = 1'b0;
    if (b[7] == 1'b0 && b[6] == 1'b0) v[7] = 1'b1;
    if (b[5] == 1'b0 && b[4] == 1'b0) v[5] = 1'b1;
    return v;
  endfunction

  // one pad poll: combo detection, capture sequence, remap and turbo advance
  task automatic take_poll(input logic [PadW-1:0] pad, output logic led);
    logic            remap;
    logic            fire;
    logic [PadW-1:0] shown;
    led   = 1'b0;
    remap = 1'b0;
    fire  = 1'b0;
    shown = pad;
    case (capture_mode)
      MODE_NORMAL: begin
        led = (pad != AllReleased);
        if (pad == ComboRSelect || pad == ComboLSelect) begin
          fire = (combo_polls == trigger_polls) && (combo_polls != CountMax);
          if (combo_polls != CountMax) combo_polls = combo_polls + 1'b1;
          if (fire) begin
            console_byte = ByteReleased;
            for_right    = (pad == ComboRSelect);
            capture_mode = MODE_WAIT_RELEASE;
            held_polls   = '0;
          end else begin
            remap = 1'b1;
          end
        end else begin
          combo_polls = '0;
          remap       = 1'b1;
        end
      end
      MODE_WAIT_RELEASE: begin
        if (pad == AllReleased) begin
          capture_mode = MODE_HOLD;
          held_polls   = '0;
        end
      end
      default: begin
        if (pad != AllReleased) begin
          if (held_polls != CountMax) held_polls = held_polls + 1'b1;
        end else begin
          held_polls = '0;
        end
        if (held_polls >= hold_polls) begin
          if (for_right) right_macro = pad | LrBits;
          else left_macro = pad | LrBits;
          capture_mode = MODE_NORMAL;
          held_polls   = '0;
          shown        = AllReleased;
          remap        = 1'b1;
        end
      end
    endcase
    if (remap) begin
      console_byte = fold_pad(shown, turbo_phase <= TurboOnLast);
      turbo_phase  = turbo_phase + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    console_word_t got;
    console_word_t want;
    logic          led;
    if (rst) begin
      trigger_polls = TriggerReset;
      hold_polls    = CaptureReset;
      console_byte  = ByteReleased;
      shift_pos     = PosDone;
      turbo_phase   = '0;
      combo_polls   = '0;
      held_polls    = '0;
      capture_mode  = MODE_NORMAL;
      for_right     = 1'b0;
      right_macro   = AllReleased;
      left_macro    = AllReleased;
      mismatches    = 0;
      console_words_q.delete();
    end else begin
      // compare each output word with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = {m_tdata[0], m_tdata[8:1], m_tdata[9], m_tdata[10]};
        if (console_words_q.size() == 0) begin
          mismatches++;
          $display("%0t: output word %h with nothing predicted", $time, m_tdata);
        end else begin
          want = console_words_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected bit %b byte %h led %b capt %b, got bit %b byte %h led %b capt %b",
                     $time, want.data_bit, want.console_byte, want.led_on, want.capturing,
                     got.data_bit, got.console_byte, got.led_on, got.capturing);
          end
        end
      end

      // register writes, unknown indexes dropped
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegTriggerHold) trigger_polls = cfg_data;
        else if (cfg_index == RegCaptureHold) hold_polls = cfg_data;
      end

      // advance the shadow state on each accepted input word
      if (s_tvalid && s_tready) begin
        led = 1'b0;
        case (s_tuser)
          CMD_POLL:   take_poll(s_tdata[PadW-1:0], led);
          CMD_STROBE: shift_pos = '0;
          CMD_CLOCK:  if (shift_pos < PosDone) shift_pos = shift_pos + 1'b1;
          default: ;
        endcase
        want.data_bit     = (shift_pos < PosDone) ? console_byte[shift_pos[2:0]] : 1'b0;
        want.console_byte = console_byte;
        want.led_on       = led;
        want.capturing    = (capture_mode != MODE_NORMAL);
        console_words_q.push_back(want);
      end
    end
    in_flight = console_words_q.size();
  end

endmodule

FILE: test/tb_gamepad_remap_turbo_shifter_core.sv
`timescale 1ns / 100ps
module tb_gamepad_remap_turbo_shifter_core;
  import grts_pkg::*;

  localparam logic [1:0]         CmdUnknown    = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused     = 8'd7;
  localparam int                 WatchdogLimit = 200;
  localparam int                 RandomWords   = 120;
  localparam int                 TailWords     = 60;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;

  int mismatches;
  int in_flight;
  int words_sent   = 0;
  int quiet_cycles = 0;
  int stall_left   = 0;
  bit gaps_on      = 1'b1;

  always #5 clk = ~clk;

  gamepad_remap_turbo_shifter_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gamepad_remap_turbo_shifter_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // stall the output side in short bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // give up when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [PadW-1:0] any_pad();
    return PadW'($urandom_range(0, 4095));
  endfunction

  // a pad with only a few buttons down
  function automatic logic [PadW-1:0] sparse_pad();
    logic [PadW-1:0] p;
    p = AllReleased;
    repeat ($urandom_range(1, 3)) p[4'($urandom_range(0, PadW - 1))] = 1'b0;
    return p;
  endfunction

  // offer one input word, with an occasional gap in front of it
  task automatic put_word(input logic [1:0] cmd, input logic [PadW-1:0] pad);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, pad};
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  task automatic poll(input logic [PadW-1:0] pad);
    put_word(CMD_POLL, pad);
  endtask

  // strobe the shifter, then clock it n times
  task automatic shift_out(input int n);
    put_word(CMD_STROBE, any_pad());
    repeat (n) put_word(CMD_CLOCK, any_pad());
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int trig, input int cap);
    write_reg(RegTriggerHold, 8'(trig));
    write_reg(RegCaptureHold, 8'(cap));
    if ($urandom_range(0, 2) == 0) write_reg(RegUnused, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (in_flight != 0);
    repeat (3) @(posedge clk);
  endtask

  // hold the combo, release, hold a pattern, then play the new macro
  task automatic capture_run(input int trig, input int cap, input bit right);
    logic [PadW-1:0] combo;
    logic [PadW-1:0] pattern;
    combo = right ? ComboRSelect : ComboLSelect;
    poll(AllReleased);
    if (trig > 1 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, trig - 1)) poll(combo);
      poll(sparse_pad());
    end
    repeat (trig + 1) poll(combo);
    repeat ($urandom_range(0, 2)) poll(any_pad());
    poll(AllReleased);
    pattern = any_pad();
    pattern[4'($urandom_range(0, 9))] = 1'b0;
    if (cap > 1 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, cap - 1)) poll(pattern);
      poll(AllReleased);
    end
    repeat ((cap == 0) ? 1 : cap) poll(pattern);
    repeat ($urandom_range(3, 8)) begin
      pattern = any_pad();
      pattern[4'($urandom_range(10, 11))] = 1'b0;
      poll(pattern);
      if ($urandom_range(0, 2) == 0) put_word(CMD_CLOCK, any_pad());
    end
    shift_out($urandom_range(6, 10));
  endtask

  task automatic noise_burst(input int n);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: poll(any_pad());
        4, 5:       poll(sparse_pad());
        6:          put_word(CMD_STROBE, any_pad());
        7, 8:       put_word(CMD_CLOCK, any_pad());
        default:    put_word(CmdUnknown, any_pad());
      endcase
    end
  endtask

  task automatic mixed_phase(input int trig, input int cap);
    repeat ($urandom_range(2, 4)) begin
      if ($urandom_range(0, 2) != 0) capture_run(trig, cap, 1'($urandom_range(0, 1)));
      else noise_burst($urandom_range(5, 15));
    end
  endtask

  initial begin
    int trig;
    int cap;
    int tail_start;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes, single buttons, turbo, opposites, shifter overrun
    poll(AllReleased);
    poll(12'h000);
    shift_out(9);
    repeat (4) poll(12'hDFF);
    poll(12'hFFD);
    poll(12'hF3F);
    poll(12'hFCF);
    poll(12'hEFF);
    poll(12'hFFE);
    put_word(CmdUnknown, 12'h000);
    shift_out(3);
    settle();

    // trigger of one, zero hold count, unknown register
    write_reg(RegUnused, 8'hFF);
    configure(1, 0);
    capture_run(1, 0, 1'b1);
    capture_run(1, 0, 1'b0);
    settle();

    // random settings with gaps on both sides
    while (words_sent < RandomWords) begin
      trig = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6);
      cap  = $urandom_range(0, 5);
      configure(trig, cap);
      mixed_phase(trig, cap);
      settle();
    end

    // longest trigger and hold
    configure(254, 255);
    capture_run(254, 255, 1'b1);
    settle();

    // saturated combo counter never starts a capture
    configure(255, 1);
    poll(AllReleased);
    repeat (258) poll(ComboLSelect);
    poll(AllReleased);
    shift_out(8);
    settle();

    // tail with no gaps or stalls
    gaps_on = 1'b0;
    configure(3, 2);
    tail_start = words_sent;
    while (words_sent < tail_start + TailWords) mixed_phase(3, 2);
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: gamepad_remap_turbo_shifter_core.f
hw/rtl/grts_pkg.sv
hw/rtl/gamepad_remap_turbo_shifter_core.sv
hw/rtl/grts_checker.sv
test/gamepad_remap_turbo_shifter_checker.sv
test/tb_gamepad_remap_turbo_shifter_core.sv
